[design/nrsa_pkg.sv]
// ----------------------------------------------------------------------------
// nrsa_pkg
// Shared types, character constants and field helpers for the RSA rudder
// sentence parser.
// ----------------------------------------------------------------------------
package nrsa_pkg;

  typedef enum logic [2:0] {
    FLD_HEADER,
    FLD_STBD_ANGLE,
    FLD_STATUS1,
    FLD_PORT_ANGLE,
    FLD_STATUS2,
    FLD_DONE
  } field_t;

  typedef enum logic [2:0] {
    RC_OK,
    RC_HEADER,
    RC_STBD_ANGLE,
    RC_STATUS1,
    RC_PORT_ANGLE,
    RC_STATUS2
  } rcode_t;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;

  localparam logic [2:0] HDR_LEN   = 3'd6;
  localparam logic [2:0] CHARS_MAX = 3'd7;

  // Parser control state; the angle accumulators travel separately because
  // their width is a module parameter.
  typedef struct packed {
    field_t     field_number;
    logic [2:0] chars_in_field;
    rcode_t     error_code;
    logic       header_match;
    logic       dot_seen;
    logic       status_char_ok;
    logic [1:0] status_flags;
  } parse_ctl_t;

  localparam parse_ctl_t CTL_RESET = '{
    field_number:   FLD_HEADER,
    chars_in_field: 3'd0,
    error_code:     RC_OK,
    header_match:   1'b1,
    dot_seen:       1'b0,
    status_char_ok: 1'b0,
    status_flags:   2'b00
  };

  // Error code reported when the given field fails.
  function automatic rcode_t field_code(field_t f);
    rcode_t r;
    case (f)
      FLD_HEADER:     r = RC_HEADER;
      FLD_STBD_ANGLE: r = RC_STBD_ANGLE;
      FLD_STATUS1:    r = RC_STATUS1;
      FLD_PORT_ANGLE: r = RC_PORT_ANGLE;
      FLD_STATUS2:    r = RC_STATUS2;
      default:        r = RC_OK;
    endcase
    return r;
  endfunction

  function automatic field_t field_after(field_t f);
    field_t r;
    case (f)
      FLD_HEADER:     r = FLD_STBD_ANGLE;
      FLD_STBD_ANGLE: r = FLD_STATUS1;
      FLD_STATUS1:    r = FLD_PORT_ANGLE;
      FLD_PORT_ANGLE: r = FLD_STATUS2;
      default:        r = FLD_DONE;
    endcase
    return r;
  endfunction

  // Expected header character at positions three to five (the "RSA" tail).
  function automatic logic [7:0] tail_char(logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd3:    r = CH_R;
      3'd4:    r = CH_S;
      3'd5:    r = CH_A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Whether the currently open field passes when it is closed.
  function automatic logic close_ok(parse_ctl_t c);
    logic r;
    case (c.field_number)
      FLD_HEADER:     r = c.header_match && (c.chars_in_field == HDR_LEN);
      FLD_STBD_ANGLE,
      FLD_PORT_ANGLE: r = (c.chars_in_field != 3'd0);
      FLD_STATUS1,
      FLD_STATUS2:    r = (c.chars_in_field == 3'd1) && c.status_char_ok;
      default:        r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

[design/nmea_rsa_sentence_parser.sv]
// ----------------------------------------------------------------------------
// nmea_rsa_sentence_parser
// Parses an RSA rudder sentence one character per cycle unless stalled and
// reports the first failing field together with the angles and status flags.
//
//   channel  direction  handshake              payload
//   input    sink       in_valid / in_ready    data_byte, end_of_sentence
//   output   source     out_valid / out_ready  result_code, starboard_angle,
//                                              starboard_status_a, port_angle,
//                                              port_status_a
//
// One character per cycle unless stalled; a character goes through an input
// register and one pass of parse logic, and the result of the end character
// is stored in the result register. Only the end character produces a result.
// Synchronous reset clears the parser to the start of a header field.
// Characters keep flowing while a result waits; the input stalls only when
// an end character meets a result register that is full and not being taken.
// ----------------------------------------------------------------------------
module nmea_rsa_sentence_parser
  import nrsa_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_sentence,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             result_code,
  output logic [ANGLE_WIDTH-1:0] starboard_angle,
  output logic                   starboard_status_a,
  output logic [ANGLE_WIDTH-1:0] port_angle,
  output logic                   port_status_a
);

  logic                   in_q_valid;
  logic [7:0]             in_q_byte;
  logic                   in_q_eos;
  logic                   advance;

  parse_ctl_t             ctl;
  logic [ANGLE_WIDTH-1:0] stbd_acc;
  logic [ANGLE_WIDTH-1:0] port_acc;
  parse_ctl_t             ctl_next;
  logic [ANGLE_WIDTH-1:0] stbd_acc_next;
  logic [ANGLE_WIDTH-1:0] port_acc_next;

  rcode_t                 res_code;
  logic [ANGLE_WIDTH-1:0] res_stbd_angle;
  logic                   res_stbd_a;
  logic [ANGLE_WIDTH-1:0] res_port_angle;
  logic                   res_port_a;

  // A plain character never needs the result register.
  assign advance  = in_q_valid && (!in_q_eos || !out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  nrsa_byte_step #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_step (
    .ctl_cur        (ctl),
    .stbd_cur       (stbd_acc),
    .port_cur       (port_acc),
    .data_byte      (in_q_byte),
    .end_of_sentence(in_q_eos),
    .ctl_next       (ctl_next),
    .stbd_next      (stbd_acc_next),
    .port_next      (port_acc_next),
    .res_code       (res_code),
    .res_stbd_angle (res_stbd_angle),
    .res_stbd_a     (res_stbd_a),
    .res_port_angle (res_port_angle),
    .res_port_a     (res_port_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_q_byte <= data_byte;
      in_q_eos  <= end_of_sentence;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= CTL_RESET;
      stbd_acc <= '0;
      port_acc <= '0;
    end else if (advance) begin
      ctl      <= ctl_next;
      stbd_acc <= stbd_acc_next;
      port_acc <= port_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_q_eos) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_q_eos) begin
      result_code        <= 3'(res_code);
      starboard_angle    <= res_stbd_angle;
      starboard_status_a <= res_stbd_a;
      port_angle         <= res_port_angle;
      port_status_a      <= res_port_a;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the result register is empty");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && in_q_eos) |=> (ctl.field_number == FLD_HEADER &&
                               ctl.error_code == RC_OK && stbd_acc == '0))
    else $error("parser did not restart after an end character");

  a_stbd_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_code == 3'(RC_HEADER) || result_code == 3'(RC_STBD_ANGLE)))
      |-> (starboard_angle == '0 && port_angle == '0))
    else $error("angle reported for a field that did not pass");

  a_port_flag_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_code != 3'(RC_OK)) |-> !port_status_a)
    else $error("port status reported on a failed sentence");

endmodule

[design/nrsa_byte_step.sv]
// ----------------------------------------------------------------------------
// nrsa_byte_step
// Combinational update of the parser state for one character, plus the
// sentence verdict and gated values when the character ends the sentence.
// ----------------------------------------------------------------------------
module nrsa_byte_step
  import nrsa_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16
) (
  input  parse_ctl_t             ctl_cur,
  input  logic [ANGLE_WIDTH-1:0] stbd_cur,
  input  logic [ANGLE_WIDTH-1:0] port_cur,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_sentence,
  output parse_ctl_t             ctl_next,
  output logic [ANGLE_WIDTH-1:0] stbd_next,
  output logic [ANGLE_WIDTH-1:0] port_next,
  output rcode_t                 res_code,
  output logic [ANGLE_WIDTH-1:0] res_stbd_angle,
  output logic                   res_stbd_a,
  output logic [ANGLE_WIDTH-1:0] res_port_angle,
  output logic                   res_port_a
);

  localparam int SUM_WIDTH = ANGLE_WIDTH + 4;

  parse_ctl_t             ctl;
  logic [ANGLE_WIDTH-1:0] stbd;
  logic [ANGLE_WIDTH-1:0] port;
  logic [ANGLE_WIDTH-1:0] acc_sel;
  logic [ANGLE_WIDTH-1:0] acc_new;
  logic [SUM_WIDTH-1:0]   acc_sum;
  logic [7:0]             delim;
  logic                   is_digit;
  logic                   fin_ok;
  logic                   stbd_pass;
  logic                   stat1_pass;
  logic                   port_pass;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign acc_sel  = (ctl_cur.field_number == FLD_STBD_ANGLE) ? stbd_cur : port_cur;

  // acc * 10 + digit, built from two shifts; saturates at all ones.
  assign acc_sum = ({4'b0000, acc_sel} << 3) + ({4'b0000, acc_sel} << 1)
                 + {{ANGLE_WIDTH{1'b0}}, data_byte[3:0]};
  assign acc_new = (|acc_sum[SUM_WIDTH-1:ANGLE_WIDTH]) ? {ANGLE_WIDTH{1'b1}}
                                                      : acc_sum[ANGLE_WIDTH-1:0];

  always_comb begin
    ctl   = ctl_cur;
    stbd  = stbd_cur;
    port  = port_cur;
    delim = (ctl_cur.field_number == FLD_STATUS2) ? CH_STAR : CH_COMMA;

    if (ctl_cur.error_code == RC_OK && ctl_cur.field_number != FLD_DONE) begin
      if (data_byte == delim) begin
        if (close_ok(ctl_cur)) begin
          ctl.field_number   = field_after(ctl_cur.field_number);
          ctl.chars_in_field = 3'd0;
          ctl.dot_seen       = 1'b0;
          ctl.status_char_ok = 1'b0;
        end else begin
          ctl.error_code = field_code(ctl_cur.field_number);
        end
      end else begin
        case (ctl_cur.field_number)
          FLD_HEADER: begin
            if (ctl_cur.chars_in_field >= 3'd3 && ctl_cur.chars_in_field <= 3'd5 &&
                data_byte != tail_char(ctl_cur.chars_in_field)) begin
              ctl.header_match = 1'b0;
            end
          end
          FLD_STBD_ANGLE, FLD_PORT_ANGLE: begin
            if (is_digit) begin
              if (!ctl_cur.dot_seen) begin
                if (ctl_cur.field_number == FLD_STBD_ANGLE) begin
                  stbd = acc_new;
                end else begin
                  port = acc_new;
                end
              end
            end else if (data_byte == CH_DOT) begin
              ctl.dot_seen = 1'b1;
            end else begin
              ctl.error_code = field_code(ctl_cur.field_number);
            end
          end
          FLD_STATUS1, FLD_STATUS2: begin
            if (ctl_cur.chars_in_field == 3'd0) begin
              ctl.status_char_ok = (data_byte == CH_A) || (data_byte == CH_V);
              if (ctl_cur.field_number == FLD_STATUS1) begin
                ctl.status_flags[0] = (data_byte == CH_A);
              end else begin
                ctl.status_flags[1] = (data_byte == CH_A);
              end
            end
          end
          default: begin
          end
        endcase
        // Every character that did not raise an error counts toward the field, up to CHARS_MAX.
        if (ctl.error_code == RC_OK && ctl_cur.chars_in_field != CHARS_MAX) begin
          ctl.chars_in_field = ctl_cur.chars_in_field + 3'd1;
        end
      end
    end
  end

  // Verdict at the end byte: an open field is closed, and if it passes the
  // next missing field is the one reported.
  assign fin_ok = close_ok(ctl);

  always_comb begin
    if (ctl.error_code != RC_OK) begin
      res_code = ctl.error_code;
    end else if (ctl.field_number == FLD_DONE) begin
      res_code = RC_OK;
    end else if (!fin_ok) begin
      res_code = field_code(ctl.field_number);
    end else begin
      res_code = field_code(field_after(ctl.field_number));
    end
  end

  assign stbd_pass  = (res_code == RC_OK) || (res_code == RC_STATUS1) ||
                      (res_code == RC_PORT_ANGLE) || (res_code == RC_STATUS2);
  assign stat1_pass = (res_code == RC_OK) || (res_code == RC_PORT_ANGLE) ||
                      (res_code == RC_STATUS2);
  assign port_pass  = (res_code == RC_OK) || (res_code == RC_STATUS2);

  assign res_stbd_angle = stbd_pass ? stbd : '0;
  assign res_stbd_a     = stat1_pass & ctl.status_flags[0];
  assign res_port_angle = port_pass ? port : '0;
  assign res_port_a     = (res_code == RC_OK) & ctl.status_flags[1];

  // The parser starts over after every sentence.
  assign ctl_next  = end_of_sentence ? CTL_RESET : ctl;
  assign stbd_next = end_of_sentence ? '0 : stbd;
  assign port_next = end_of_sentence ? '0 : port;

endmodule

[sim/tb_nmea_rsa_sentence_parser.sv]
// ----------------------------------------------------------------------------
// tb_nmea_rsa_sentence_parser
// Self-checking bench for the RSA rudder sentence parser. A table of
// hand-written sentences covers every error code, saturation, open fields at
// the end character and ignored trailing bytes. Random sentences follow:
// most are well formed with random content, the rest are corrupted,
// truncated or plain noise. Both handshakes stall at random. Every result is
// checked field by field against its pinned row, else a cycle-free model.
// ----------------------------------------------------------------------------
module tb_nmea_rsa_sentence_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import nrsa_pkg::*;

  localparam int ANGLE_W = 16;
  localparam int CHAR_TARGET = 950;
  localparam int QUIET_FROM = 820;
  localparam int ROWS = 22;

  typedef struct packed {
    rcode_t             code;
    logic [ANGLE_W-1:0] stbd;
    logic               s1a;
    logic [ANGLE_W-1:0] port;
    logic               s2a;
  } rudder_result_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           data_byte;
  logic                 end_of_sentence;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           result_code;
  logic [ANGLE_W-1:0]   starboard_angle;
  logic                 starboard_status_a;
  logic [ANGLE_W-1:0]   port_angle;
  logic                 port_status_a;

  // Parser state as the bench sees it.
  field_t               p_field;
  logic [2:0]           p_chars;
  rcode_t               p_err;
  bit                   p_hdr_ok;
  bit                   p_dot;
  bit                   p_stat_ok;
  logic [ANGLE_W-1:0]   p_stbd;
  logic [ANGLE_W-1:0]   p_port;
  logic [1:0]           p_flags;

  rudder_result_t       rudder_results_q[$];
  logic [7:0]           sentence_q[$];

  // The expectation typed into the table travels with the character on the bus.
  bit                   cur_pinned;
  rudder_result_t       cur_want;

  bit                   quiet;
  int                   hold_len;
  int                   failures;
  int                   results_checked;
  int                   chars_sent;
  int                   sentences_sent;

  string row_text [ROWS] = '{
    "$GPRSA,12.5,A,7.25,V*3C",
    "$GPRSA,65535,A,0,A*",
    "$GPRSA,9999999,V,99999999.9,A*00",
    "$GPRSB,1,A,1,A*",
    "$GPRS,1,A,1,A*",
    "$GPRSA,,A,1,A*",
    "$GPRSA,1x,A,1,A*",
    "$GPRSA,...,A,3,A*",
    "$GPRSA,5,X,1,A*",
    "$GPRSA,5,AV,1,A*",
    "$GPRSA,5,*,1,A*",
    "$GPRSA,5,A,,A*",
    "$GPRSA,5,A,7,,*",
    "$GPRSA,5,A,7,A",
    "$GPRSA,5,A",
    "$GPRSA",
    ",",
    "$GPRSA,1,A,2,V*,,xx,*",
    "$IIRSA,0.0,V,180.5,A*hh",
    "$GPRSA,5,A,7,",
    "$GPXRSA,1,A,1,A*",
    "$GPRSAXYZ,1.2.3,A,42,V*"
  };

  bit row_pinned [ROWS] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0
  };

  rudder_result_t row_want [ROWS] = '{
    '{RC_OK,         16'd12,    1'b1, 16'd7,     1'b0},
    '{RC_OK,         16'd65535, 1'b1, 16'd0,     1'b1},
    '{RC_OK,         16'd65535, 1'b0, 16'd65535, 1'b1},
    '{RC_HEADER,     16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_HEADER,     16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_STBD_ANGLE, 16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_STBD_ANGLE, 16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_OK,         16'd0,     1'b1, 16'd3,     1'b1},
    '{RC_STATUS1,    16'd5,     1'b0, 16'd0,     1'b0},
    '{RC_STATUS1,    16'd5,     1'b0, 16'd0,     1'b0},
    '{RC_STATUS1,    16'd5,     1'b0, 16'd0,     1'b0},
    '{RC_PORT_ANGLE, 16'd5,     1'b1, 16'd0,     1'b0},
    '{RC_STATUS2,    16'd5,     1'b1, 16'd7,     1'b0},
    '{RC_OK,         16'd5,     1'b1, 16'd7,     1'b1},
    '{RC_PORT_ANGLE, 16'd5,     1'b1, 16'd0,     1'b0},
    '{RC_STBD_ANGLE, 16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_HEADER,     16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_OK,         16'd1,     1'b1, 16'd2,     1'b0},
    '{RC_OK,         16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_OK,         16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_OK,         16'd0,     1'b0, 16'd0,     1'b0},
    '{RC_OK,         16'd0,     1'b0, 16'd0,     1'b0}
  };

  nmea_rsa_sentence_parser #(
    .ANGLE_WIDTH(ANGLE_W)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .end_of_sentence   (end_of_sentence),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .result_code       (result_code),
    .starboard_angle   (starboard_angle),
    .starboard_status_a(starboard_status_a),
    .port_angle        (port_angle),
    .port_status_a     (port_status_a)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  task automatic restart_sentence;
    p_field   = FLD_HEADER;
    p_chars   = 3'd0;
    p_err     = RC_OK;
    p_hdr_ok  = 1'b1;
    p_dot     = 1'b0;
    p_stat_ok = 1'b0;
    p_stbd    = '0;
    p_port    = '0;
    p_flags   = 2'b00;
  endtask

  // Field codes follow the field order, one above the field index.
  function automatic rcode_t fail_code(field_t f);
    return rcode_t'(f + 3'd1);
  endfunction

  task automatic bump_chars;
    if (p_chars != 3'd7) p_chars = p_chars + 3'd1;
  endtask

  task automatic close_open_field;
    bit ok;
    case (p_field)
      FLD_HEADER:     ok = p_hdr_ok && (p_chars == 3'd6);
      FLD_STBD_ANGLE,
      FLD_PORT_ANGLE: ok = (p_chars != 3'd0);
      FLD_STATUS1,
      FLD_STATUS2:    ok = (p_chars == 3'd1) && p_stat_ok;
      default:        ok = 1'b1;
    endcase
    if (!ok) begin
      p_err = fail_code(p_field);
    end else begin
      if (p_field != FLD_DONE) p_field = field_t'(p_field + 3'd1);
      p_chars   = 3'd0;
      p_dot     = 1'b0;
      p_stat_ok = 1'b0;
    end
  endtask

  task automatic parse_rudder_char(input logic [7:0] c, input logic eos,
                                   output bit has_result, output rudder_result_t r);
    logic [ANGLE_W-1:0] acc;
    int unsigned        v;
    logic [7:0]         delim;
    has_result = 1'b0;
    r = '0;
    if (p_err == RC_OK && p_field != FLD_DONE) begin
      case (p_field)
        FLD_HEADER: begin
          if (c == CH_COMMA) begin
            close_open_field();
          end else begin
            if ((p_chars == 3'd3 && c != CH_R) || (p_chars == 3'd4 && c != CH_S) ||
                (p_chars == 3'd5 && c != CH_A))
              p_hdr_ok = 1'b0;
            bump_chars();
          end
        end
        FLD_STBD_ANGLE, FLD_PORT_ANGLE: begin
          acc = (p_field == FLD_STBD_ANGLE) ? p_stbd : p_port;
          if (c == CH_COMMA) begin
            close_open_field();
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            // Digits after the first dot belong to the fraction and are dropped.
            if (!p_dot) begin
              v = 32'(acc) * 32'd10 + 32'(c) - 32'(CH_ZERO);
              acc = (v > 32'(16'hFFFF)) ? '1 : v[ANGLE_W-1:0];
            end
            bump_chars();
          end else if (c == CH_DOT) begin
            p_dot = 1'b1;
            bump_chars();
          end else begin
            p_err = fail_code(p_field);
          end
          if (p_field == FLD_STBD_ANGLE) p_stbd = acc;
          else if (p_field == FLD_PORT_ANGLE && p_err == RC_OK) p_port = acc;
        end
        default: begin
          // Status1 ends at a comma, status2 at an asterisk; the other one is content.
          delim = (p_field == FLD_STATUS2) ? CH_STAR : CH_COMMA;
          if (c == delim) begin
            close_open_field();
          end else begin
            if (p_chars == 3'd0) begin
              p_stat_ok = (c == CH_A) || (c == CH_V);
              p_flags[(p_field == FLD_STATUS2) ? 1 : 0] = (c == CH_A);
            end
            bump_chars();
          end
        end
      endcase
    end
    if (eos) begin
      if (p_err == RC_OK && p_field != FLD_DONE) begin
        close_open_field();
        if (p_err == RC_OK && p_field != FLD_DONE) p_err = fail_code(p_field);
      end
      has_result = 1'b1;
      r.code = p_err;
      r.stbd = (p_err == RC_OK || p_err > RC_STBD_ANGLE) ? p_stbd : '0;
      r.s1a  = (p_err == RC_OK || p_err > RC_STATUS1) ? p_flags[0] : 1'b0;
      r.port = (p_err == RC_OK || p_err > RC_PORT_ANGLE) ? p_port : '0;
      r.s2a  = (p_err == RC_OK) ? p_flags[1] : 1'b0;
      restart_sentence();
    end
  endtask

  // ------------------------------------------------------ monitor / check

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    failures++;
  endtask

  always @(posedge clk) begin : scoreboard
    bit             got;
    rudder_result_t pred;
    rudder_result_t want;
    rudder_result_t actual;
    if (!rst && in_valid && in_ready) begin
      parse_rudder_char(data_byte, end_of_sentence, got, pred);
      if (got) rudder_results_q.push_back(cur_pinned ? cur_want : pred);
    end
    if (!rst && out_valid && out_ready) begin
      actual = '{rcode_t'(result_code), starboard_angle, starboard_status_a,
                 port_angle, port_status_a};
      if (rudder_results_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual code %0d", $time, result_code);
        failures++;
      end else begin
        want = rudder_results_q.pop_front();
        results_checked++;
        if (actual.code !== want.code) report_field("result_code", want.code, actual.code);
        if (actual.stbd !== want.stbd) report_field("starboard_angle", want.stbd, actual.stbd);
        if (actual.s1a !== want.s1a) report_field("starboard_status_a", want.s1a, actual.s1a);
        if (actual.port !== want.port) report_field("port_angle", want.port, actual.port);
        if (actual.s2a !== want.s2a) report_field("port_status_a", want.s2a, actual.s2a);
      end
    end
  end

  // ------------------------------------------------------------- receiver

  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_ready = 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- sender

  task automatic send_char(input logic [7:0] c, input logic eos, input bit pin,
                           input rudder_result_t want);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid        = 1'b1;
    data_byte       = c;
    end_of_sentence = eos;
    cur_pinned      = pin;
    cur_want        = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic add_angle;
    int mode;
    int n;
    mode = $urandom_range(0, 19);
    case (mode)
      0: ;
      1: begin
        n = $urandom_range(1, 3);
        repeat (n) sentence_q.push_back(CH_DOT);
      end
      2: begin
        sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        sentence_q.push_back(8'($urandom_range(0, 255)));
        sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      3, 4: begin
        // Five to nine digits: can saturate the accumulator and the character count.
        n = $urandom_range(5, 9);
        repeat (n) sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      5, 6: begin
        n = $urandom_range(1, 8);
        repeat (n) sentence_q.push_back(($urandom_range(0, 3) == 0) ? CH_DOT :
                                        CH_ZERO + 8'($urandom_range(0, 9)));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1) begin
          sentence_q.push_back(CH_DOT);
          n = $urandom_range(0, 2);
          repeat (n) sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
    endcase
  endtask

  task automatic add_status;
    int mode;
    mode = $urandom_range(0, 19);
    case (mode)
      0: ;
      1: sentence_q.push_back(8'($urandom_range(0, 255)));
      2: begin
        sentence_q.push_back($urandom_range(0, 1) ? CH_A : CH_V);
        sentence_q.push_back($urandom_range(0, 1) ? CH_A : CH_V);
      end
      default: sentence_q.push_back($urandom_range(0, 1) ? CH_A : CH_V);
    endcase
  endtask

  task automatic build_random_sentence;
    int    kind;
    int    n;
    int    cut;
    string hex;
    hex = "0123456789ABCDEF";
    sentence_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 24);
      repeat (n) sentence_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      sentence_q.push_back("$");
      sentence_q.push_back("A" + 8'($urandom_range(0, 25)));
      sentence_q.push_back("A" + 8'($urandom_range(0, 25)));
      sentence_q.push_back(CH_R);
      sentence_q.push_back(CH_S);
      sentence_q.push_back(CH_A);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: sentence_q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
          1: sentence_q.delete($urandom_range(0, 5));
          default: sentence_q.insert($urandom_range(0, 6), 8'($urandom_range(0, 255)));
        endcase
      end
      sentence_q.push_back(CH_COMMA);
      add_angle();
      sentence_q.push_back(CH_COMMA);
      add_status();
      sentence_q.push_back(CH_COMMA);
      add_angle();
      sentence_q.push_back(CH_COMMA);
      add_status();
      sentence_q.push_back(CH_STAR);
      if ($urandom_range(0, 4) != 0) begin
        sentence_q.push_back(hex[$urandom_range(0, 15)]);
        sentence_q.push_back(hex[$urandom_range(0, 15)]);
      end
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 5);
        repeat (n) sentence_q.push_back(8'($urandom_range(0, 255)));
      end
      if (kind >= 82) begin
        cut = $urandom_range(1, sentence_q.size());
        while (sentence_q.size() > cut) void'(sentence_q.pop_back());
      end
    end
  endtask

  initial begin
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    quiet = 1'b0;
    hold_len = 0;
    failures = 0;
    results_checked = 0;
    chars_sent = 0;
    sentences_sent = 0;
    cur_pinned = 1'b0;
    cur_want = '0;
    in_valid = 1'b0;
    data_byte = 8'h00;
    end_of_sentence = 1'b0;
    restart_sentence();
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      for (int i = 0; i < row_text[r].len(); i++)
        send_char(row_text[r][i], i == row_text[r].len() - 1, row_pinned[r], row_want[r]);
      sentences_sent++;
    end

    while (chars_sent < CHAR_TARGET) begin
      // Hold the output back long enough for results to pile up and stall the input.
      if (!held && chars_sent >= 300) begin
        hold_len = 400;
        held = 1'b1;
      end
      if (!drained && chars_sent >= 600) begin
        in_valid = 1'b0;
        while (rudder_results_q.size() != 0) @(negedge clk);
        drained = 1'b1;
      end
      if (chars_sent >= QUIET_FROM) quiet = 1'b1;
      build_random_sentence();
      for (int i = 0; i < sentence_q.size(); i++)
        send_char(sentence_q[i], i == sentence_q.size() - 1, 1'b0, '0);
      sentences_sent++;
    end

    in_valid = 1'b0;
    while (rudder_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d characters in %0d sentences, checked %0d results, %0d failures.",
             chars_sent, sentences_sent, results_checked, failures);
    $display("Run included a long output stall, a full drain pause and a stall-free tail.");
    if (failures == 0) begin
      $display("tb_nmea_rsa_sentence_parser passed");
    end else begin
      $display("tb_nmea_rsa_sentence_parser failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Timeout with %0d results still expected.", rudder_results_q.size());
    $display("tb_nmea_rsa_sentence_parser failed");
    $finish;
  end

endmodule

[filelist.f]
design/nrsa_pkg.sv
design/nrsa_byte_step.sv
design/nmea_rsa_sentence_parser.sv
sim/tb_nmea_rsa_sentence_parser.sv
